// ===== rtl/thr_pkg.sv =====
// shared types and constants for the telemetry history ring
// no dependencies; used by thr_ctrl and telemetry_history_ring by scoped name
`default_nettype none

package thr_pkg;

  localparam int RING_DEPTH_DEF  = 256;
  localparam int FRAME_WIDTH_DEF = 32;

  localparam int CAP_CFG_W  = 9;
  localparam int KIND_W     = 2;
  localparam int FRAME_IN_W = 32;
  localparam int TIME_W     = 48;
  localparam int CNT_W      = 32;
  localparam int IDX_W      = 8;
  localparam int ERRK_W     = 2;
  localparam int CODE_W     = 32;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 256;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PARSE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LINK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd3;

  // last error record
  localparam logic [ERRK_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERRK_W-1:0] ERR_PARSE = 2'd1;
  localparam logic [ERRK_W-1:0] ERR_LINK  = 2'd2;

  // counters as seen after an item has been applied
  typedef struct packed {
    logic [CAP_CFG_W-1:0] fill_count;
    logic [CNT_W-1:0]     accepted_total;
    logic [CNT_W-1:0]     parse_error_total;
    logic [CNT_W-1:0]     link_error_total;
    logic [ERRK_W-1:0]    last_error_kind;
    logic [CODE_W-1:0]    last_error_code;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/thr_mem.sv =====
// sample store: one synchronous memory holding time, sequence and frame per entry
// one write port, one read port with registered read data; uses no package items
`default_nettype none

module thr_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 112
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/thr_ctrl.sv =====
// ring control: capacity, write pointer, fill count, counters and error record
// computes store addresses for add and read items; depends on thr_pkg
`default_nettype none

module thr_ctrl #(
  parameter int RING_DEPTH = thr_pkg::RING_DEPTH_DEF,
  parameter int PTR_W      = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         item_acc,
  input  wire logic [thr_pkg::KIND_W-1:0]   item_kind,
  input  wire logic [thr_pkg::CODE_W-1:0]   item_err_code,
  input  wire logic [thr_pkg::IDX_W-1:0]    item_rd_idx,
  input  wire logic                         cfg_we,
  input  wire logic [thr_pkg::CAP_CFG_W-1:0] cfg_value,
  output      logic                         wr_en,
  output      logic [PTR_W-1:0]             wr_addr,
  output      logic [thr_pkg::CNT_W-1:0]    wr_seq,
  output      logic                         rd_en,
  output      logic [PTR_W-1:0]             rd_addr,
  output      logic                         rd_hit,
  output      thr_pkg::status_t             stat_nxt
);

  localparam int CAP_W = $clog2(RING_DEPTH + 1);
  localparam int PW1   = PTR_W + 1;
  localparam int SUM_W = ((PTR_W > thr_pkg::IDX_W) ? PTR_W : thr_pkg::IDX_W) + 1;

  logic [CAP_W-1:0]                cap_r, cap_nxt;
  logic [CAP_W-1:0]                count_r, count_nxt;
  logic [PTR_W-1:0]                wptr_r, wptr_nxt;
  logic [thr_pkg::CNT_W-1:0]       stamp_r, stamp_nxt;
  logic [thr_pkg::CNT_W-1:0]       acc_cnt_r, acc_cnt_nxt;
  logic [thr_pkg::CNT_W-1:0]       parse_cnt_r, parse_cnt_nxt;
  logic [thr_pkg::CNT_W-1:0]       link_cnt_r, link_cnt_nxt;
  logic [thr_pkg::ERRK_W-1:0]      ekind_r, ekind_nxt;
  logic [thr_pkg::CODE_W-1:0]      ecode_r, ecode_nxt;

  logic [PW1-1:0]   wptr_inc;
  logic [PTR_W-1:0] oldest;
  logic [SUM_W-1:0] rd_sum;
  logic [SUM_W-1:0] rd_slot;
  logic [31:0]      cap_clamp;
  logic             is_add;
  logic             is_read;

  assign is_add  = item_acc && (item_kind == thr_pkg::KIND_ADD);
  assign is_read = item_acc && (item_kind == thr_pkg::KIND_READ);

  // the pointer always stays below capacity, so the slot is the pointer itself
  assign wptr_inc = PW1'(wptr_r) + PW1'(1);

  // for an index below the fill count, oldest + index stays below twice the capacity
  assign oldest  = (count_r >= cap_r) ? wptr_r : '0;
  assign rd_sum  = SUM_W'(oldest) + SUM_W'(item_rd_idx);
  assign rd_slot = (rd_sum >= SUM_W'(cap_r)) ? (rd_sum - SUM_W'(cap_r)) : rd_sum;
  assign rd_hit  = SUM_W'(item_rd_idx) < SUM_W'(count_r);

  assign wr_en   = is_add;
  assign wr_addr = wptr_r;
  assign wr_seq  = stamp_r;
  assign rd_en   = is_read && rd_hit;
  assign rd_addr = rd_slot[PTR_W-1:0];

  always_comb begin
    if (cfg_value == '0) begin
      cap_clamp = 32'd1;
    end else if (32'(cfg_value) > 32'(RING_DEPTH)) begin
      cap_clamp = 32'(RING_DEPTH);
    end else begin
      cap_clamp = 32'(cfg_value);
    end
  end

  always_comb begin
    cap_nxt       = cap_r;
    count_nxt     = count_r;
    wptr_nxt      = wptr_r;
    stamp_nxt     = stamp_r;
    acc_cnt_nxt   = acc_cnt_r;
    parse_cnt_nxt = parse_cnt_r;
    link_cnt_nxt  = link_cnt_r;
    ekind_nxt     = ekind_r;
    ecode_nxt     = ecode_r;
    if (item_acc) begin
      case (item_kind)
        thr_pkg::KIND_ADD: begin
          stamp_nxt   = stamp_r + 1'b1;
          acc_cnt_nxt = acc_cnt_r + 1'b1;
          wptr_nxt    = (wptr_inc == PW1'(cap_r)) ? '0 : wptr_inc[PTR_W-1:0];
          if (count_r < cap_r) begin
            count_nxt = count_r + 1'b1;
          end
          ekind_nxt = thr_pkg::ERR_NONE;
          ecode_nxt = '0;
        end
        thr_pkg::KIND_PARSE: begin
          parse_cnt_nxt = parse_cnt_r + 1'b1;
          ekind_nxt     = thr_pkg::ERR_PARSE;
          ecode_nxt     = item_err_code;
        end
        thr_pkg::KIND_LINK: begin
          link_cnt_nxt = link_cnt_r + 1'b1;
          ekind_nxt    = thr_pkg::ERR_LINK;
          ecode_nxt    = item_err_code;
        end
        default: begin
        end
      endcase
    end
    // capacity only changes while the ring is empty
    if (cfg_we && (count_r == '0)) begin
      cap_nxt  = CAP_W'(cap_clamp);
      wptr_nxt = '0;
    end
  end

  always_comb begin
    stat_nxt.fill_count        = thr_pkg::CAP_CFG_W'(count_nxt);
    stat_nxt.accepted_total    = acc_cnt_nxt;
    stat_nxt.parse_error_total = parse_cnt_nxt;
    stat_nxt.link_error_total  = link_cnt_nxt;
    stat_nxt.last_error_kind   = ekind_nxt;
    stat_nxt.last_error_code   = ecode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(RING_DEPTH);
      count_r     <= '0;
      wptr_r      <= '0;
      stamp_r     <= '0;
      acc_cnt_r   <= '0;
      parse_cnt_r <= '0;
      link_cnt_r  <= '0;
      ekind_r     <= thr_pkg::ERR_NONE;
      ecode_r     <= '0;
    end else begin
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      wptr_r      <= wptr_nxt;
      stamp_r     <= stamp_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      parse_cnt_r <= parse_cnt_nxt;
      link_cnt_r  <= link_cnt_nxt;
      ekind_r     <= ekind_nxt;
      ecode_r     <= ecode_nxt;
    end
  end

  a_count_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("fill count above capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (32'(cap_r) <= 32'(RING_DEPTH)))
    else $error("capacity out of range");

  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < cap_r) |-> (CAP_W'(wptr_r) == count_r))
    else $error("write pointer does not match fill count before wrap");

  a_stamp_eq_adds: assert property (@(posedge clk) disable iff (!rst_n)
    stamp_r == acc_cnt_r)
    else $error("sequence stamp and add counter diverged");

endmodule

`default_nettype wire

// ===== rtl/telemetry_history_ring.sv =====
// telemetry history ring: an input transfer's result passes through the sample store
// read in stage 1 and then the output register.
// throughput is one item per cycle while the result side takes transfers.
// reset clears the pointer, fill count, counters and error record and sets
// capacity to RING_DEPTH; store contents stay undefined, no clearing pass is run.
// depends on thr_pkg, thr_ctrl and thr_mem
`default_nettype none

module telemetry_history_ring #(
  parameter int RING_DEPTH  = thr_pkg::RING_DEPTH_DEF,
  parameter int FRAME_WIDTH = thr_pkg::FRAME_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata: frame_data[31:0], arrival_ms[79:32], error_code[111:80], read_index[119:112]
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [thr_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: kind[1:0]
  input  wire logic [thr_pkg::KIND_W-1:0]      in_tuser,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  // out_tdata: read_frame[31:0], read_sequence[63:32], read_time_ms[111:64],
  // fill_count[120:112], accepted_total[152:121], parse_error_total[184:153],
  // link_error_total[216:185], last_error_kind[218:217], last_error_code[250:219], zeros
  output      logic [thr_pkg::OUT_DATA_W-1:0]  out_tdata,
  // out_tuser: read_valid[0]
  output      logic                            out_tuser,
  // cfg_tdata: ring_capacity[8:0]
  input  wire logic                            cfg_tvalid,
  output      logic                            cfg_tready,
  input  wire logic [thr_pkg::CAP_CFG_W-1:0]   cfg_tdata
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int MEM_DW = thr_pkg::TIME_W + thr_pkg::CNT_W + FRAME_WIDTH;
  localparam int PAD_W  = thr_pkg::OUT_DATA_W - 251;

  logic                          in_acc;
  logic [thr_pkg::FRAME_IN_W-1:0] in_frame;
  logic [thr_pkg::TIME_W-1:0]    in_time;
  logic [thr_pkg::CODE_W-1:0]    in_code;
  logic [thr_pkg::IDX_W-1:0]     in_idx;

  logic                          wr_en, rd_en, rd_hit;
  logic [PTR_W-1:0]              wr_addr, rd_addr;
  logic [thr_pkg::CNT_W-1:0]     wr_seq;
  logic [MEM_DW-1:0]             wr_data, rd_data;
  thr_pkg::status_t              stat_nxt;

  logic                          s1_v_r;
  logic                          s1_hit_r;
  thr_pkg::status_t              s1_stat_r;
  logic                          s1_adv;
  logic                          out_load;

  logic [thr_pkg::FRAME_IN_W-1:0] rd_frame;
  logic [thr_pkg::CNT_W-1:0]     rd_seq;
  logic [thr_pkg::TIME_W-1:0]    rd_time;

  logic                          out_v_r;
  logic                          out_user_r;
  logic [thr_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  assign in_frame = in_tdata[31:0];
  assign in_time  = in_tdata[79:32];
  assign in_code  = in_tdata[111:80];
  assign in_idx   = in_tdata[119:112];

  assign out_load  = !out_v_r || out_tready;
  assign s1_adv    = s1_v_r && out_load;
  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;

  thr_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_acc      (in_acc),
    .item_kind     (in_tuser),
    .item_err_code (in_code),
    .item_rd_idx   (in_idx),
    .cfg_we        (cfg_tvalid),
    .cfg_value     (cfg_tdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_seq        (wr_seq),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_hit        (rd_hit),
    .stat_nxt      (stat_nxt)
  );

  // an add is written at its own transfer edge, so a later read never overlaps it
  assign wr_data = {in_time, wr_seq, FRAME_WIDTH'(in_frame)};

  thr_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (PTR_W),
    .DW    (MEM_DW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_frame = thr_pkg::FRAME_IN_W'(rd_data[FRAME_WIDTH-1:0]);
  assign rd_seq   = rd_data[FRAME_WIDTH +: thr_pkg::CNT_W];
  assign rd_time  = rd_data[FRAME_WIDTH + thr_pkg::CNT_W +: thr_pkg::TIME_W];

  // stage 1 waits for the store read; it holds while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_hit_r  <= (in_tuser == thr_pkg::KIND_READ) && rd_hit;
      s1_stat_r <= stat_nxt;
    end
  end

  always_comb begin
    out_data_nxt = {
      {PAD_W{1'b0}},
      s1_stat_r.last_error_code,
      s1_stat_r.last_error_kind,
      s1_stat_r.link_error_total,
      s1_stat_r.parse_error_total,
      s1_stat_r.accepted_total,
      s1_stat_r.fill_count,
      s1_hit_r ? rd_time  : '0,
      s1_hit_r ? rd_seq   : '0,
      s1_hit_r ? rd_frame : '0
    };
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_user_r <= s1_hit_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
